FILE: sv/evseg_pkg.sv
// evseg_pkg: shared constants for the energy voice-activity segmenter
// register indexes, reset values, command codes and field widths
// no dependencies
`default_nettype none

package evseg_pkg;

	// field widths
	localparam int unsigned THR_W    = 16;
	localparam int unsigned CNTR_W   = 8;
	localparam int unsigned MINLEN_W = 20;
	localparam int unsigned OUTLEN_W = 20;
	localparam int unsigned ENERGY_W = 44;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned CFG_W    = 20;
	localparam int unsigned CFG_IDX_W = 3;

	// parameter defaults
	localparam int unsigned MAX_BUFFER_SAMPLES_DEF = 16384;
	localparam int unsigned LENGTH_BITS_DEF        = 20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_IDLE   = 3'd4;

	// register reset values
	localparam logic [THR_W-1:0]    START_THR_RST = 16'd100;
	localparam logic [THR_W-1:0]    STOP_THR_RST  = 16'd50;
	localparam logic [CNTR_W-1:0]   SILENCE_RST   = 8'd8;
	localparam logic [MINLEN_W-1:0] MIN_SEG_RST   = 20'd8000;
	localparam logic [CNTR_W-1:0]   CMD_IDLE_RST  = 8'd20;

	// input commands
	localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_MODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PAUSE    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESUME   = 2'd3;

	// modes
	localparam logic MODE_WAKE    = 1'b0;
	localparam logic MODE_COMMAND = 1'b1;

	localparam logic [CNTR_W-1:0] CNTR_MAX = '1;

endpackage

`default_nettype wire

FILE: sv/energy_vad_segmenter.sv
// energy_vad_segmenter: per-buffer energy voice detector with hysteresis,
// silence timeout, segment length check and command-mode timeout
// depends on evseg_pkg
`default_nettype none

// One shared multiplier does all the multiplications under a small sequencer,
// so the block takes one item at a time. A command is handled as it is taken.
// A sample is transferred, squared and then accumulated. After the last sample
// of a buffer is accumulated, the multiplier forms threshold squared, then
// that times the buffer's sample count, and a decision step compares it with the
// energy sum and updates the detector. The result sits in an output register,
// so the next item is taken while it waits; a further buffer end stalls in
// its decision cycle until the previous result has been transferred.
// Thresholds are compared exactly as energy against threshold squared times
// count. Samples beyond MAX_BUFFER_SAMPLES in one buffer are dropped, and the
// segment length saturates at 2^LENGTH_BITS - 1.
module energy_vad_segmenter #(
	parameter int unsigned MAX_BUFFER_SAMPLES = evseg_pkg::MAX_BUFFER_SAMPLES_DEF,
	parameter int unsigned LENGTH_BITS        = evseg_pkg::LENGTH_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration
	input  wire                                    cfg_we,
	input  wire  [evseg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [evseg_pkg::CFG_W-1:0]            cfg_data,
	// input items
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  [evseg_pkg::CMD_W-1:0]            cmd,
	input  wire  signed [evseg_pkg::SAMPLE_W-1:0]  sample,
	input  wire                                    last_in_buffer,
	input  wire                                    mode_value,
	// results
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic                                   ignored,
	output logic                                   speaking,
	output logic                                   segment_started,
	output logic                                   segment_ended,
	output logic                                   segment_accepted,
	output logic [evseg_pkg::OUTLEN_W-1:0]         segment_length,
	output logic                                   command_expired,
	output logic                                   mode_now
);

	localparam int unsigned CNT_W = $clog2(MAX_BUFFER_SAMPLES + 1);
	localparam int unsigned MB_W  = (CNT_W > evseg_pkg::SAMPLE_W) ? CNT_W
		: evseg_pkg::SAMPLE_W;
	localparam int unsigned MA_W  = 2 * evseg_pkg::THR_W;
	localparam int unsigned PW    = MA_W + MB_W;
	localparam int unsigned LS_W  = ((LENGTH_BITS > CNT_W) ? LENGTH_BITS : CNT_W) + 1;
	localparam int unsigned LC_W  = (LENGTH_BITS > evseg_pkg::MINLEN_W) ? LENGTH_BITS
		: evseg_pkg::MINLEN_W;
	localparam int unsigned LO_W  = (LENGTH_BITS > evseg_pkg::OUTLEN_W) ? LENGTH_BITS
		: evseg_pkg::OUTLEN_W;
	localparam logic [CNT_W-1:0]       CNT_MAX = CNT_W'(MAX_BUFFER_SAMPLES);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd2;
	localparam logic [2:0] S_THR  = 3'd3;
	localparam logic [2:0] S_SCL  = 3'd4;
	localparam logic [2:0] S_DEC  = 3'd5;

	logic [2:0] state_q;

	// configuration registers
	logic [evseg_pkg::THR_W-1:0]    start_thr_q;
	logic [evseg_pkg::THR_W-1:0]    stop_thr_q;
	logic [evseg_pkg::CNTR_W-1:0]   silence_bufs_q;
	logic [evseg_pkg::MINLEN_W-1:0] min_seg_q;
	logic [evseg_pkg::CNTR_W-1:0]   cmd_idle_q;

	// detector state
	logic [evseg_pkg::ENERGY_W-1:0] energy_sum_q;
	logic [CNT_W-1:0]               buf_cnt_q;
	logic                           in_speech_q;
	logic [evseg_pkg::CNTR_W-1:0]   silence_cnt_q;
	logic [evseg_pkg::CNTR_W-1:0]   idle_cnt_q;
	logic [LENGTH_BITS-1:0]         seg_samples_q;
	logic                           mode_q;
	logic                           cmd_decoded_q;
	logic                           paused_q;

	// item being worked on
	logic [evseg_pkg::SAMPLE_W-1:0] mag_q;
	logic                           last_q;
	logic [PW-1:0]                  prod_q;

	logic in_xfer;
	logic dec_go;
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign dec_go   = (state_q == S_DEC) && !(out_valid && !out_ready);

	// shared multiplier
	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [PW-1:0]   mul_p;
	logic [evseg_pkg::THR_W-1:0] thr_sel;

	assign thr_sel = in_speech_q ? stop_thr_q : start_thr_q;

	always_comb begin
		unique case (state_q)
			S_SQ: begin
				mul_a = MA_W'(mag_q);
				mul_b = MB_W'(mag_q);
			end
			S_THR: begin
				mul_a = MA_W'(thr_sel);
				mul_b = MB_W'(thr_sel);
			end
			S_SCL: begin
				mul_a = prod_q[MA_W-1:0];
				mul_b = MB_W'(buf_cnt_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// saturating accumulate of the squared sample
	logic [evseg_pkg::ENERGY_W:0] energy_add;
	assign energy_add = {1'b0, energy_sum_q}
		+ (evseg_pkg::ENERGY_W + 1)'(prod_q[MA_W-1:0]);

	// buffer-end decision
	logic                         ign_d;
	logic                         in_speech_d;
	logic [evseg_pkg::CNTR_W-1:0] silence_cnt_d;
	logic [evseg_pkg::CNTR_W-1:0] idle_cnt_d;
	logic [LENGTH_BITS-1:0]       seg_d;
	logic [LENGTH_BITS-1:0]       len_d;
	logic                         mode_d;
	logic                         cmd_decoded_d;
	logic                         started_d;
	logic                         ended_d;
	logic                         accepted_d;
	logic                         expired_d;
	logic [LS_W-1:0]              seg_sum;
	logic [LO_W-1:0]              len_ext;
	logic                         below;
	logic                         above;

	assign below = (PW'(energy_sum_q) < prod_q);
	assign above = (PW'(energy_sum_q) > prod_q);

	always_comb begin
		ign_d         = paused_q || (cmd_decoded_q && (mode_q == evseg_pkg::MODE_COMMAND));
		in_speech_d   = in_speech_q;
		silence_cnt_d = silence_cnt_q;
		idle_cnt_d    = idle_cnt_q;
		seg_d         = seg_samples_q;
		len_d         = seg_samples_q;
		mode_d        = mode_q;
		cmd_decoded_d = cmd_decoded_q;
		started_d     = 1'b0;
		ended_d       = 1'b0;
		accepted_d    = 1'b0;
		expired_d     = 1'b0;
		seg_sum       = '0;
		if (!ign_d) begin
			if (in_speech_d) begin
				if (below) begin
					silence_cnt_d = (silence_cnt_d == evseg_pkg::CNTR_MAX) ? silence_cnt_d
						: silence_cnt_d + 1'b1;
				end else begin
					silence_cnt_d = '0;
					idle_cnt_d    = '0;
				end
			end else if (above) begin
				in_speech_d   = 1'b1;
				silence_cnt_d = '0;
				idle_cnt_d    = '0;
				seg_d         = '0;
				started_d     = 1'b1;
			end
			len_d = '0;
			if (in_speech_d) begin
				seg_sum = LS_W'(seg_d) + LS_W'(buf_cnt_q);
				seg_d   = (seg_sum > LS_W'(LEN_MAX)) ? LEN_MAX : seg_sum[LENGTH_BITS-1:0];
				len_d   = seg_d;
				if (silence_cnt_d >= silence_bufs_q) begin
					in_speech_d   = 1'b0;
					silence_cnt_d = '0;
					ended_d       = 1'b1;
					if (LC_W'(seg_d) >= LC_W'(min_seg_q)) begin
						accepted_d = 1'b1;
						if (mode_d == evseg_pkg::MODE_COMMAND)
							cmd_decoded_d = 1'b1;
					end
					seg_d = '0;
				end
			end
			if ((mode_d == evseg_pkg::MODE_COMMAND) && !in_speech_d) begin
				idle_cnt_d = (idle_cnt_d == evseg_pkg::CNTR_MAX) ? idle_cnt_d
					: idle_cnt_d + 1'b1;
				if (idle_cnt_d >= cmd_idle_q) begin
					idle_cnt_d = '0;
					mode_d     = evseg_pkg::MODE_WAKE;
					expired_d  = 1'b1;
				end
			end
		end
		len_ext = LO_W'(len_d);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q    <= evseg_pkg::START_THR_RST;
			stop_thr_q     <= evseg_pkg::STOP_THR_RST;
			silence_bufs_q <= evseg_pkg::SILENCE_RST;
			min_seg_q      <= evseg_pkg::MIN_SEG_RST;
			cmd_idle_q     <= evseg_pkg::CMD_IDLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				evseg_pkg::REG_START_THR: start_thr_q    <= cfg_data[evseg_pkg::THR_W-1:0];
				evseg_pkg::REG_STOP_THR:  stop_thr_q     <= cfg_data[evseg_pkg::THR_W-1:0];
				evseg_pkg::REG_SILENCE:   silence_bufs_q <= cfg_data[evseg_pkg::CNTR_W-1:0];
				evseg_pkg::REG_MIN_SEG:   min_seg_q      <= cfg_data[evseg_pkg::MINLEN_W-1:0];
				evseg_pkg::REG_CMD_IDLE:  cmd_idle_q     <= cfg_data[evseg_pkg::CNTR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			energy_sum_q  <= '0;
			buf_cnt_q     <= '0;
			in_speech_q   <= 1'b0;
			silence_cnt_q <= '0;
			idle_cnt_q    <= '0;
			seg_samples_q <= '0;
			mode_q        <= evseg_pkg::MODE_WAKE;
			cmd_decoded_q <= 1'b0;
			paused_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (cmd)
							evseg_pkg::CMD_SAMPLE: state_q <= S_SQ;
							evseg_pkg::CMD_SET_MODE: begin
								mode_q        <= mode_value;
								cmd_decoded_q <= 1'b0;
								idle_cnt_q    <= '0;
							end
							evseg_pkg::CMD_PAUSE: begin
								if (!paused_q) begin
									paused_q      <= 1'b1;
									in_speech_q   <= 1'b0;
									silence_cnt_q <= '0;
									seg_samples_q <= '0;
								end
							end
							evseg_pkg::CMD_RESUME: begin
								if (paused_q) begin
									paused_q      <= 1'b0;
									cmd_decoded_q <= 1'b0;
									idle_cnt_q    <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				S_SQ: state_q <= S_ACC;
				S_ACC: begin
					// samples past the buffer limit are dropped
					if (buf_cnt_q < CNT_MAX) begin
						buf_cnt_q    <= buf_cnt_q + 1'b1;
						energy_sum_q <= energy_add[evseg_pkg::ENERGY_W] ? '1
							: energy_add[evseg_pkg::ENERGY_W-1:0];
					end
					state_q <= last_q ? S_THR : S_IDLE;
				end
				S_THR: state_q <= S_SCL;
				S_SCL: state_q <= S_DEC;
				S_DEC: begin
					if (dec_go) begin
						energy_sum_q  <= '0;
						buf_cnt_q     <= '0;
						in_speech_q   <= in_speech_d;
						silence_cnt_q <= silence_cnt_d;
						idle_cnt_q    <= idle_cnt_d;
						seg_samples_q <= seg_d;
						mode_q        <= mode_d;
						cmd_decoded_q <= cmd_decoded_d;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and multiplier result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q  <= sample[evseg_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
			last_q <= last_in_buffer;
		end
		if ((state_q == S_SQ) || (state_q == S_THR) || (state_q == S_SCL))
			prod_q <= mul_p;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (dec_go)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dec_go) begin
			ignored          <= ign_d;
			speaking         <= in_speech_d;
			segment_started  <= started_d;
			segment_ended    <= ended_d;
			segment_accepted <= accepted_d;
			segment_length   <= len_ext[evseg_pkg::OUTLEN_W-1:0];
			command_expired  <= expired_d;
			mode_now         <= mode_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/evseg_checker.sv
// evseg_checker: port-level assertions for the energy voice segmenter
// depends on evseg_pkg; bound to energy_vad_segmenter below
`default_nettype none

module evseg_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_valid,
	input wire                               in_ready,
	input wire [evseg_pkg::CMD_W-1:0]        cmd,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire                               ignored,
	input wire                               speaking,
	input wire                               segment_started,
	input wire                               segment_ended,
	input wire                               segment_accepted,
	input wire [evseg_pkg::OUTLEN_W-1:0]     segment_length,
	input wire                               command_expired,
	input wire                               mode_now
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segment_length)
			&& $stable(speaking) && $stable(ignored) && $stable(mode_now))
		else $error("result changed while stalled");

	// a sample keeps the shared unit busy for the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == evseg_pkg::CMD_SAMPLE) |=> !in_ready)
		else $error("ready after sample transfer");

	// an accepted segment is an ended one, and ending leaves silence
	a_accept_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment_accepted |-> segment_ended && !speaking)
		else $error("accepted without end");

	// a dropped buffer raises no events
	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ignored |-> !segment_started && !segment_ended
			&& !segment_accepted && !command_expired)
		else $error("event on ignored buffer");

	// expiry returns to wake-word mode
	a_expire_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_expired |-> (mode_now == evseg_pkg::MODE_WAKE) && !speaking)
		else $error("expiry without wake mode");

endmodule

bind energy_vad_segmenter evseg_checker u_evseg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.cmd              (cmd),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.ignored          (ignored),
	.speaking         (speaking),
	.segment_started  (segment_started),
	.segment_ended    (segment_ended),
	.segment_accepted (segment_accepted),
	.segment_length   (segment_length),
	.command_expired  (command_expired),
	.mode_now         (mode_now)
);

`default_nettype wire
